@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: label");
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: label");
`endif

@@ rtl/core/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU slave package
// Shared payload types, constants and the CRC helper.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	localparam int unsigned REG_COUNT_DEF     = 64;
	localparam int unsigned FRAME_BYTES_DEF   = 64;
	localparam int unsigned MAX_READ_REGS_DEF = 29;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] LOW_MASK = 16'h00FF;

	localparam logic [7:0] FC_READ   = 8'd3;
	localparam logic [7:0] FC_WRITE1 = 8'd6;
	localparam logic [7:0] FC_WRITEN = 8'd16;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
	} out_item_t;

	// A completed, CRC-checked request handed from the receiver to the executor.
	typedef struct packed {
		logic [7:0]  addr_byte;
		logic [7:0]  fc;
		logic [15:0] start_reg;
		logic [15:0] qty;
	} req_t;

	// One byte-wide CRC update, eight bit steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

@@ rtl/core/modbus_rtu_slave_engine_core.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU slave engine
// Receives request bytes, executes holding-register requests, sends replies.
// ----------------------------------------------------------------------------
// Usage: in_valid/in_ready transfer one in_item_t: a received byte or a
// silence timeout. cfg_valid/cfg_ready transfer the slave address; write it
// only while the block is idle. out_valid/out_ready transfer response bytes,
// with tx_last on the final byte.
// The receiver takes a received byte whenever it is not holding input off. The
// last byte of a good frame hands the request to the executor; input is then
// held off until the executor is idle and has taken it. The executor writes the
// registers one at a time from the frame buffer port and sends one response
// byte per cycle while the output is not stalled, with a wait state after each
// register read. Reset clears the receiver, sets the address to 1 and makes
// all holding registers read as zero at once. A stalled receiver of replies
// holds the executor; a new frame may be received meanwhile.
module modbus_rtu_slave_engine_core import mbrtu_pkg::*; #(
	parameter int unsigned REG_COUNT     = REG_COUNT_DEF,
	parameter int unsigned FRAME_BYTES   = FRAME_BYTES_DEF,
	parameter int unsigned MAX_READ_REGS = MAX_READ_REGS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_data,
	input  in_item_t  in_data,
	input  logic      in_valid,
	output logic      in_ready,
	output out_item_t out_data,
	output logic      out_valid,
	input  logic      out_ready
);

	logic [7:0] slave_address_q;
	req_t req;
	logic req_valid, req_ready;
	logic [$clog2(FRAME_BYTES)-1:0] fb_raddr;
	logic [7:0] fb_rdata;

	assign cfg_ready = 1'b1;

	// Slave address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slave_address_q <= 8'd1;
		else if (cfg_valid) slave_address_q <= cfg_data;
	end

	mbrtu_rx #(.FRAME_BYTES(FRAME_BYTES)) u_rx (
		.clk, .arst_n, .slave_address(slave_address_q), .in_data, .in_valid, .in_ready,
		.fb_raddr, .fb_rdata, .req, .req_valid, .req_ready
	);

	mbrtu_exec #(
		.REG_COUNT(REG_COUNT), .FRAME_BYTES(FRAME_BYTES), .MAX_READ_REGS(MAX_READ_REGS)
	) u_exec (
		.clk, .arst_n, .req, .req_valid, .req_ready, .fb_raddr, .fb_rdata,
		.out_data, .out_valid, .out_ready
	);

endmodule

@@ rtl/core/mbrtu_rx.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU receiver front
// Collects request bytes, runs the CRC and hands good frames onward.
// ----------------------------------------------------------------------------
module mbrtu_rx import mbrtu_pkg::*; #(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] slave_address,
	input  in_item_t  in_data,
	input  logic      in_valid,
	output logic      in_ready,
	// Frame buffer read port for the executor.
	input  logic [$clog2(FRAME_BYTES)-1:0] fb_raddr,
	output logic [7:0] fb_rdata,
	output req_t      req,
	output logic      req_valid,
	input  logic      req_ready
);

	localparam int unsigned AW = $clog2(FRAME_BYTES);
	localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

	logic [7:0]  frame_mem [FRAME_BYTES];
	logic        in_frame_q;
	logic [CW-1:0] count_q;
	logic [7:0]  fc_q;
	logic [15:0] crc_q;
	logic [7:0]  addr_hi_q, addr_lo_q, qty_hi_q, b0_q;
	logic [7:0]  frame_lo_q;
	logic        busy_q;

	logic [15:0] crc_nx;
	logic [CW:0] cnt_nx;
	logic [17:0] need;
	logic [7:0]  qty_lo;
	logic        take;
	logic        fc_bad;
	logic        frame_end;

	// The receiver holds off new bytes while a finished frame waits for the executor to take it.
	assign in_ready  = !busy_q;
	assign req_valid = busy_q;
	assign take      = in_valid && in_ready;
	assign crc_nx    = crc_byte(crc_q, in_data.rx_byte);
	assign cnt_nx    = {1'b0, count_q} + 1'b1;
	assign qty_lo    = (cnt_nx == (CW+1)'(6)) ? in_data.rx_byte : frame_lo_q;
	assign fc_bad    = (cnt_nx == (CW+1)'(2)) && in_data.rx_byte != FC_READ
		&& in_data.rx_byte != FC_WRITE1 && in_data.rx_byte != FC_WRITEN;
	assign frame_end = (cnt_nx >= (CW+1)'(8)) && ({{(17-CW){1'b0}}, cnt_nx} >= need);

	// Needed length, known once the quantity is in.
	always_comb begin
		need = 18'd8;
		if (fc_q == FC_WRITEN && cnt_nx >= (CW+1)'(6))
			need = {1'b0, qty_hi_q, qty_lo, 1'b0} + 18'd9;
	end

	// Frame buffer writes and registered read.
	always_ff @(posedge clk) begin
		if (take && in_data.cmd == CMD_BYTE) begin
			if (!in_frame_q) frame_mem[0] <= in_data.rx_byte;
			else if (count_q < CW'(FRAME_BYTES)) frame_mem[count_q[AW-1:0]] <= in_data.rx_byte;
		end
		fb_rdata <= frame_mem[fb_raddr];
	end

	// Receive state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			fc_q       <= '0;
			crc_q      <= CRC_INIT;
			busy_q     <= 1'b0;
			addr_hi_q  <= '0;
			addr_lo_q  <= '0;
			qty_hi_q   <= '0;
			frame_lo_q <= '0;
			b0_q       <= '0;
			req        <= '0;
		end else begin
			if (busy_q && req_ready) busy_q <= 1'b0;
			if (take) begin
				if (in_data.cmd == CMD_TIMEOUT) begin
					in_frame_q <= 1'b0; count_q <= '0; fc_q <= '0; crc_q <= CRC_INIT;
				end else if (!in_frame_q) begin
					if (in_data.rx_byte == slave_address) begin
						in_frame_q <= 1'b1;
						count_q    <= CW'(1);
						b0_q       <= in_data.rx_byte;
						crc_q      <= crc_byte(CRC_INIT, in_data.rx_byte);
					end
				end else if (count_q >= CW'(FRAME_BYTES)) begin
					in_frame_q <= 1'b0; count_q <= '0; fc_q <= '0; crc_q <= CRC_INIT;
				end else begin
					unique case (cnt_nx[CW-1:0])
						CW'(3): addr_hi_q  <= in_data.rx_byte;
						CW'(4): addr_lo_q  <= in_data.rx_byte;
						CW'(5): qty_hi_q   <= in_data.rx_byte;
						CW'(6): frame_lo_q <= in_data.rx_byte;
						default: ;
					endcase
					// A bad function code, an oversized write or the last byte ends the frame.
					if (fc_bad || need > 18'(FRAME_BYTES) || frame_end) begin
						in_frame_q <= 1'b0; count_q <= '0; fc_q <= '0; crc_q <= CRC_INIT;
						if (frame_end && crc_nx == 16'd0) begin
							busy_q        <= 1'b1;
							req.addr_byte <= b0_q;
							req.fc        <= fc_q;
							req.start_reg <= {addr_hi_q, addr_lo_q};
							req.qty       <= {qty_hi_q, frame_lo_q};
						end
					end else begin
						count_q <= cnt_nx[CW-1:0];
						crc_q   <= crc_nx;
						if (cnt_nx == (CW+1)'(2)) fc_q <= in_data.rx_byte;
					end
				end
			end
		end
	end

endmodule

@@ rtl/core/mbrtu_exec.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU request executor
// Reads or writes holding registers and streams the response bytes.
// ----------------------------------------------------------------------------
module mbrtu_exec import mbrtu_pkg::*; #(
	parameter int unsigned REG_COUNT     = REG_COUNT_DEF,
	parameter int unsigned FRAME_BYTES   = FRAME_BYTES_DEF,
	parameter int unsigned MAX_READ_REGS = MAX_READ_REGS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  logic      req_valid,
	output logic      req_ready,
	output logic [$clog2(FRAME_BYTES)-1:0] fb_raddr,
	input  logic [7:0] fb_rdata,
	output out_item_t out_data,
	output logic      out_valid,
	input  logic      out_ready
);

	localparam int unsigned AW  = $clog2(FRAME_BYTES);
	localparam int unsigned RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_CLEAR, S_WR_HI, S_WR_LO, S_RD_REG, S_TX, S_WAIT
	} state_t;

	state_t state_q;
	logic [15:0] regs_mem [REG_COUNT];
	logic [REG_COUNT-1:0] reg_valid_q;
	req_t   req_q;
	logic [16:0] idx_q;
	logic [7:0]  nbytes_q;
	logic [7:0]  tx_idx_q;
	logic [7:0]  hi_q;
	logic [15:0] crc_q;
	logic [15:0] rd_q;
	logic        phase_q;
	logic [7:0]  tx_b;
	logic [16:0] end_addr;
	logic [RAW-1:0] reg_ix;
	logic        tx_go;
	logic        wr1_ok;

	assign req_ready = (state_q == S_IDLE);
	assign end_addr  = {1'b0, req_q.start_reg} + {1'b0, req_q.qty};
	assign reg_ix    = RAW'(req_q.start_reg + idx_q[15:0]);
	assign tx_go     = (state_q == S_TX) && (!out_valid || out_ready);
	assign wr1_ok    = {1'b0, req_q.start_reg} < 17'(REG_COUNT);

	// Register file with valid bits so reset reads as zero.
	always_ff @(posedge clk) begin
		rd_q <= regs_mem[reg_ix];
		if (state_q == S_WR_LO) regs_mem[reg_ix] <= {hi_q, fb_rdata};
		else if (state_q == S_CHECK && req_q.fc == FC_WRITE1 && wr1_ok)
			regs_mem[reg_ix] <= req_q.qty;
	end

	// Byte of the response body at tx_idx_q.
	always_comb begin
		unique case (tx_idx_q)
			8'd0: tx_b = req_q.addr_byte;
			8'd1: tx_b = req_q.fc;
			8'd2: tx_b = (req_q.fc == FC_READ) ? {req_q.qty[6:0], 1'b0} : req_q.start_reg[15:8];
			8'd3: tx_b = req_q.start_reg[7:0];
			8'd4: tx_b = req_q.qty[15:8];
			default: tx_b = req_q.qty[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; reg_valid_q <= '0; out_valid <= 1'b0; out_data <= '0;
			req_q <= '0; idx_q <= '0; nbytes_q <= '0; tx_idx_q <= '0; hi_q <= '0;
			crc_q <= CRC_INIT; phase_q <= 1'b0; fb_raddr <= '0;
		end else begin
			if (out_valid && out_ready && !tx_go) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_valid) begin
					req_q <= req; idx_q <= '0; tx_idx_q <= '0; crc_q <= CRC_INIT;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					priority if (req_q.fc == FC_READ) begin
						if (req_q.qty == 16'd0 || req_q.qty > 16'(MAX_READ_REGS)
							|| end_addr > 17'(REG_COUNT)) state_q <= S_IDLE;
						else begin nbytes_q <= 8'(3 + 2 * req_q.qty[5:0]); state_q <= S_RD_REG; end
					end else if (req_q.fc == FC_WRITE1) begin
						if (!wr1_ok) state_q <= S_IDLE;
						else begin
							reg_valid_q[reg_ix] <= 1'b1; nbytes_q <= 8'd6; state_q <= S_TX;
						end
					end else begin
						if (req_q.qty == 16'd0 || end_addr > 17'(REG_COUNT)) state_q <= S_IDLE;
						else begin
							fb_raddr <= AW'(7); nbytes_q <= 8'd6; state_q <= S_WR_HI;
						end
					end
				end
				S_WR_HI: begin
					fb_raddr <= fb_raddr + 1'b1; state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					hi_q <= fb_rdata; fb_raddr <= fb_raddr + 1'b1; state_q <= S_WR_LO;
				end
				S_WR_LO: begin
					reg_valid_q[reg_ix] <= 1'b1;
					fb_raddr <= fb_raddr + 1'b1;
					idx_q <= idx_q + 1'b1;
					if (idx_q + 1'b1 == {1'b0, req_q.qty}) state_q <= S_TX;
					else state_q <= S_CLEAR;
				end
				S_RD_REG: state_q <= S_TX;
				S_TX: if (tx_go) begin
					out_valid <= 1'b1;
					if (tx_idx_q < nbytes_q) begin
						logic [7:0] b;
						b = tx_b;
						if (req_q.fc == FC_READ && tx_idx_q >= 8'd3) begin
							b = phase_q ? (reg_valid_q[reg_ix] ? rd_q[7:0] : 8'd0)
								: (reg_valid_q[reg_ix] ? rd_q[15:8] : 8'd0);
						end
						out_data <= '{tx_byte: b, tx_last: 1'b0};
						crc_q <= crc_byte(crc_q, b);
						tx_idx_q <= tx_idx_q + 1'b1;
						if (req_q.fc == FC_READ && tx_idx_q >= 8'd3) begin
							phase_q <= !phase_q;
							if (phase_q) begin idx_q <= idx_q + 1'b1; state_q <= S_WAIT; end
						end
					end else if (tx_idx_q == nbytes_q) begin
						out_data <= '{tx_byte: crc_q[7:0], tx_last: 1'b0};
						tx_idx_q <= tx_idx_q + 1'b1;
					end else begin
						out_data <= '{tx_byte: crc_q[15:8], tx_last: 1'b1};
						phase_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_WAIT: state_q <= S_TX;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/mbrtu_checker.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU slave port checker
// Port-level properties of the slave engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mbrtu_checker import mbrtu_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input out_item_t out_data,
	input logic      out_valid,
	input logic      out_ready
);
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CHK_NEXT(a_no_reset_out, clk, arst_n, !$past(arst_n), !out_valid)
	`CHK_IMPLY(a_out_known, clk, arst_n, out_valid, !$isunknown(out_data))
endmodule

bind modbus_rtu_slave_engine_core mbrtu_checker u_chk (
	.clk, .arst_n, .out_data, .out_valid, .out_ready
);

@@ sim/modbus_rtu_slave_engine_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus RTU slave engine checker
// Watches the configuration, request and response channels. It keeps its own
// copy of the receiver state and the holding registers, predicts the response
// bytes of every complete request on the request channel, and compares them in order.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_engine_checker import mbrtu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic [7:0] cfg_data,
	input  in_item_t  in_data,
	input  logic      in_valid,
	input  logic      in_ready,
	input  out_item_t out_data,
	input  logic      out_valid,
	input  logic      out_ready,
	output int        fail_count,
	output int        pending_bytes
);

	localparam int NREGS   = 64;
	localparam int MAXBYTES = 64;
	localparam int MAXREAD = 29;

	logic [7:0]  my_addr;
	logic        rx_active;
	int          rx_count;
	logic [7:0]  rx_fc;
	logic [7:0]  rx_buf [MAXBYTES];
	logic [15:0] rx_crc;
	logic [15:0] regs [NREGS];
	out_item_t   reply_q [$];

	// Reflected CRC-16 update over one byte.
	function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) r = (r >> 1) ^ 16'hA001;
			else r = r >> 1;
		end
		return r;
	endfunction

	function automatic logic [15:0] word_at(input int i);
		return {rx_buf[i], rx_buf[i + 1]};
	endfunction

	task automatic rx_idle();
		rx_active = 1'b0;
		rx_count  = 0;
		rx_fc     = 8'h00;
		rx_crc    = 16'hFFFF;
	endtask

	// Execute a complete, CRC-clean request and queue the reply bytes.
	task automatic run_request(input logic [7:0] fc);
		logic [7:0]  tx [$];
		logic [15:0] crc;
		int addr;
		int qty;
		addr = word_at(2);
		qty  = word_at(4);
		if (fc == FC_READ) begin
			if (qty < 1 || qty > MAXREAD || addr + qty > NREGS) return;
			tx = '{rx_buf[0], rx_buf[1], 8'(qty * 2)};
			for (int i = 0; i < qty; i++) begin
				tx.push_back(regs[addr + i][15:8]);
				tx.push_back(regs[addr + i][7:0]);
			end
		end else if (fc == FC_WRITE1) begin
			if (addr >= NREGS) return;
			regs[addr] = 16'(qty);
			for (int i = 0; i < 8; i++) tx.push_back(rx_buf[i]);
		end else if (fc == FC_WRITEN) begin
			if (qty < 1 || addr + qty > NREGS || qty * 2 + 9 > MAXBYTES) return;
			for (int i = 0; i < qty; i++) regs[addr + i] = word_at(7 + 2 * i);
			for (int i = 0; i < 6; i++) tx.push_back(rx_buf[i]);
		end else begin
			return;
		end
		// Single writes echo the request, CRC included; others get a fresh CRC.
		if (fc != FC_WRITE1) begin
			crc = 16'hFFFF;
			foreach (tx[k]) crc = crc16_update(crc, tx[k]);
			tx.push_back(crc[7:0]);
			tx.push_back(crc[15:8]);
		end
		foreach (tx[k]) reply_q.push_back('{tx_byte: tx[k], tx_last: (k == tx.size() - 1)});
	endtask

	// Receiver: one transfer on the request channel.
	task automatic take_item(input in_item_t it);
		int need;
		logic [7:0] fc;
		if (it.cmd == CMD_TIMEOUT) begin
			rx_idle();
			return;
		end
		if (!rx_active) begin
			if (it.rx_byte == my_addr) begin
				rx_buf[0] = it.rx_byte;
				rx_count  = 1;
				rx_active = 1'b1;
				rx_crc    = crc16_update(16'hFFFF, it.rx_byte);
			end
			return;
		end
		if (rx_count >= MAXBYTES) begin
			rx_idle();
			return;
		end
		rx_buf[rx_count] = it.rx_byte;
		rx_count++;
		rx_crc = crc16_update(rx_crc, it.rx_byte);
		if (rx_count == 2) begin
			if (it.rx_byte != FC_READ && it.rx_byte != FC_WRITE1 && it.rx_byte != FC_WRITEN) begin
				rx_idle();
				return;
			end
			rx_fc = it.rx_byte;
		end
		need = 8;
		if (rx_fc == FC_WRITEN && rx_count >= 6) begin
			need = int'(word_at(4)) * 2 + 9;
			if (need > MAXBYTES) begin
				rx_idle();
				return;
			end
		end
		if (rx_count < 8 || rx_count < need) return;
		fc = rx_fc;
		if (rx_crc != 16'h0000) begin
			rx_idle();
			return;
		end
		rx_idle();
		run_request(fc);
	endtask

	// Sample every channel at the rising edge and keep the prediction current.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_addr = 8'd1;
			rx_idle();
			for (int i = 0; i < NREGS; i++) regs[i] = 16'h0000;
			reply_q.delete();
			fail_count    = 0;
			pending_bytes = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					$error("unexpected response byte %h last %b", out_data.tx_byte, out_data.tx_last);
					fail_count++;
				end else begin
					if (out_data.tx_byte !== reply_q[0].tx_byte) begin
						$error("tx_byte: expected %h, actual %h", reply_q[0].tx_byte, out_data.tx_byte);
						fail_count++;
					end
					if (out_data.tx_last !== reply_q[0].tx_last) begin
						$error("tx_last: expected %b, actual %b", reply_q[0].tx_last, out_data.tx_last);
						fail_count++;
					end
					void'(reply_q.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) my_addr = cfg_data;
			if (in_valid && in_ready) take_item(in_data);
			pending_bytes = reply_q.size();
		end
	end

endmodule

@@ sim/modbus_rtu_slave_engine_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus RTU slave engine testbench
// Sends Modbus request frames, broken frames, noise and silence timeouts to
// the engine under random stalls on both sides, rewrites the slave address
// between phases, and lets the checker judge every response byte.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_engine_core_tb;
	import mbrtu_pkg::*;

	localparam int ITEM_GOAL = 360;

	logic      clk;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [7:0] cfg_data;
	in_item_t  in_data;
	logic      in_valid;
	logic      in_ready;
	out_item_t out_data;
	logic      out_valid;
	logic      out_ready;
	int        fail_count;
	int        pending_bytes;

	int         item_count;
	bit         calm;
	bit         hold_req;
	bit         hold_seen;
	logic [7:0] slave_id;

	modbus_rtu_slave_engine_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_data (out_data),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	modbus_rtu_slave_engine_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_data      (in_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.out_data     (out_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fail_count   (fail_count),
		.pending_bytes(pending_bytes)
	);

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run time limit.
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	// Response side: random stall bursts, one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (800) @(negedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	function automatic logic [15:0] frame_crc(input logic [7:0] fr [$]);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (fr[i]) begin
			c ^= {8'h00, fr[i]};
			for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	// One transfer on the request channel; called at a falling edge.
	task automatic put_item(input logic c, input logic [7:0] b);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_data  = '{cmd: c, rx_byte: b};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		item_count++;
	endtask

	// Send a frame with its CRC appended, optionally corrupted.
	task automatic send_frame(input logic [7:0] fr [$], input bit spoil);
		logic [15:0] c;
		c = frame_crc(fr);
		if (spoil) c ^= 16'(1 << $urandom_range(0, 15));
		fr.push_back(c[7:0]);
		fr.push_back(c[15:8]);
		foreach (fr[i]) put_item(CMD_BYTE, fr[i]);
	endtask

	function automatic logic [7:0] head_of(input logic [7:0] fc, input int a, input int q,
			output logic [7:0] fr [$]);
		fr = '{slave_id, fc, 8'(a >> 8), 8'(a), 8'(q >> 8), 8'(q)};
		return fc;
	endfunction

	task automatic send_read(input int a, input int q, input bit spoil);
		logic [7:0] fr [$];
		void'(head_of(FC_READ, a, q, fr));
		send_frame(fr, spoil);
	endtask

	task automatic send_write1(input int a, input logic [15:0] v, input bit spoil);
		logic [7:0] fr [$];
		void'(head_of(FC_WRITE1, a, v, fr));
		send_frame(fr, spoil);
	endtask

	task automatic send_writen(input int a, input int q, input bit spoil);
		logic [7:0] fr [$];
		void'(head_of(FC_WRITEN, a, q, fr));
		fr.push_back(8'(q * 2));
		for (int i = 0; i < q; i++) begin
			fr.push_back(8'($urandom));
			fr.push_back(($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom));
		end
		send_frame(fr, spoil);
	endtask

	// Change the slave address once all replies are out and the block settled.
	task automatic set_address(input logic [7:0] a);
		put_item(CMD_TIMEOUT, 8'($urandom));
		in_valid = 1'b0;
		wait (pending_bytes == 0);
		repeat (300) @(negedge clk);
		cfg_data  = a;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		slave_id  = a;
	endtask

	task automatic random_frame();
		int  pick;
		int  q;
		int  a;
		logic [7:0] fr [$];
		logic [7:0] bad_fc;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			q = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 29) : $urandom_range(1, 6);
			send_read($urandom_range(0, 64 - q), q, 1'b0);
		end else if (pick < 46) begin
			send_write1($urandom_range(0, 63), 16'($urandom), 1'b0);
		end else if (pick < 64) begin
			q = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 27) : $urandom_range(1, 5);
			send_writen($urandom_range(0, 64 - q), q, 1'b0);
		end else if (pick < 72) begin
			// Requests with a bad quantity or outside the register map.
			case ($urandom_range(0, 5))
				0: send_read($urandom_range(0, 63), 0, 1'b0);
				1: send_read($urandom_range(0, 20), $urandom_range(30, 65535), 1'b0);
				2: send_read($urandom_range(40, 65535), $urandom_range(25, 29), 1'b0);
				3: send_write1($urandom_range(64, 65535), 16'($urandom), 1'b0);
				4: send_writen($urandom_range(0, 63), 0, 1'b0);
				default: send_writen($urandom_range(60, 63), $urandom_range(5, 8), 1'b0);
			endcase
		end else if (pick < 79) begin
			case ($urandom_range(0, 2))
				0: send_read($urandom_range(0, 40), $urandom_range(1, 20), 1'b1);
				1: send_write1($urandom_range(0, 63), 16'($urandom), 1'b1);
				default: send_writen($urandom_range(0, 50), $urandom_range(1, 10), 1'b1);
			endcase
		end else if (pick < 84) begin
			do bad_fc = 8'($urandom); while (bad_fc == FC_READ || bad_fc == FC_WRITE1
				|| bad_fc == FC_WRITEN);
			put_item(CMD_BYTE, slave_id);
			put_item(CMD_BYTE, bad_fc);
			put_item(CMD_TIMEOUT, 8'($urandom));
		end else if (pick < 88) begin
			// Write request too long for the frame buffer.
			void'(head_of(FC_WRITEN, $urandom_range(0, 63), $urandom_range(28, 65535), fr));
			foreach (fr[i]) put_item(CMD_BYTE, fr[i]);
			repeat ($urandom_range(0, 3)) put_item(CMD_BYTE, 8'($urandom));
			put_item(CMD_TIMEOUT, 8'($urandom));
		end else if (pick < 93) begin
			// Frame cut short by a silence timeout.
			void'(head_of(FC_READ, $urandom_range(0, 30), $urandom_range(1, 20), fr));
			repeat ($urandom_range(1, 6)) put_item(CMD_BYTE, fr.pop_front());
			put_item(CMD_TIMEOUT, 8'($urandom));
		end else begin
			// Line noise, then resynchronize.
			repeat ($urandom_range(1, 6)) put_item(CMD_BYTE, 8'($urandom));
			put_item(CMD_TIMEOUT, 8'($urandom));
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 8'd0;
		in_valid   = 1'b0;
		in_data    = '0;
		item_count = 0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		hold_seen  = 1'b0;
		slave_id   = 8'd1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: register map corners, largest read, timeout, foreign address.
		send_write1(63, 16'hFFFF, 1'b0);
		send_read(35, 29, 1'b0);
		put_item(CMD_BYTE, 8'hF7);
		put_item(CMD_TIMEOUT, 8'h00);

		set_address(8'd247);
		while (item_count < ITEM_GOAL) begin
			if (item_count > 120 && slave_id == 8'd247) set_address(8'($urandom_range(2, 246)));
			if (item_count > 240 && slave_id != 8'd1) set_address(8'd1);
			if (item_count > 160 && !hold_seen) begin
				hold_req  = 1'b1;
				hold_seen = 1'b1;
			end
			if (item_count > ITEM_GOAL - 60) calm = 1'b1;
			random_frame();
		end
		in_valid = 1'b0;

		fork
			wait (pending_bytes == 0);
			repeat (200000) @(negedge clk);
		join_any
		repeat (300) @(negedge clk);
		if (fail_count == 0 && pending_bytes == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_rx.sv
rtl/core/mbrtu_exec.sv
rtl/core/modbus_rtu_slave_engine_core.sv
rtl/core/mbrtu_checker.sv
sim/modbus_rtu_slave_engine_checker.sv
sim/modbus_rtu_slave_engine_core_tb.sv
